>>> sv/spi_led_matrix_pwm_driver_core_defines.svh
// assertion macros for the led matrix driver rtl
// no dependencies; included by files that carry assertions
`ifndef SPI_LED_MATRIX_PWM_DRIVER_CORE_DEFINES_SVH
`define SPI_LED_MATRIX_PWM_DRIVER_CORE_DEFINES_SVH

// same-cycle implication
`define SLMPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define SLMPD_ASSERT_ALWAYS(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cons)) \
    else $error(msg);

`endif

>>> sv/slmpd_pkg.sv
// types, constants and the pwm level table of the led matrix driver
// no dependencies
`default_nettype none

package slmpd_pkg;

  localparam int unsigned RING_BYTES = 32;
  localparam int unsigned PWM_SLOTS  = 63;
  localparam int unsigned COLUMNS    = 8;
  localparam int unsigned ROWS       = 8;
  localparam int unsigned IDX_W      = $clog2(RING_BYTES);
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned LEVEL_W    = 6;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_LATCH = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [7:0] col_drive;
    logic [7:0] row_drive;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_LATCH = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [LEVEL_W-1:0] pwm_level(input logic [3:0] nib);
    logic [LEVEL_W-1:0] lvl;
    unique case (nib)
      4'd0:    lvl = 6'd0;
      4'd1:    lvl = 6'd1;
      4'd2:    lvl = 6'd2;
      4'd3:    lvl = 6'd3;
      4'd4:    lvl = 6'd4;
      4'd5:    lvl = 6'd5;
      4'd6:    lvl = 6'd6;
      4'd7:    lvl = 6'd7;
      4'd8:    lvl = 6'd8;
      4'd9:    lvl = 6'd11;
      4'd10:   lvl = 6'd15;
      4'd11:   lvl = 6'd20;
      4'd12:   lvl = 6'd26;
      4'd13:   lvl = 6'd35;
      4'd14:   lvl = 6'd47;
      default: lvl = 6'd63;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> sv/slmpd_fifo.sv
// small first-in first-out queue of words
// no dependencies
`default_nettype none

module slmpd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/slmpd_front.sv
// front end: takes input words, decodes them into commands, queues them
// depends on slmpd_pkg and slmpd_fifo
`default_nettype none

module slmpd_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire slmpd_pkg::in_word_t  word_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_ready_i,
  output slmpd_pkg::cmd_t           cmd_o
);

  slmpd_pkg::cmd_t             dec;
  logic [$bits(slmpd_pkg::cmd_t)-1:0] q_data;
  logic                        q_empty;

  always_comb begin
    dec.data = '0;
    unique case (word_i.func)
      slmpd_pkg::FUNC_BYTE: begin
        dec.op   = slmpd_pkg::OP_BYTE;
        dec.data = word_i.rx_byte;
      end
      slmpd_pkg::FUNC_LATCH: dec.op = slmpd_pkg::OP_LATCH;
      slmpd_pkg::FUNC_TICK:  dec.op = slmpd_pkg::OP_TICK;
      default:               dec.op = slmpd_pkg::OP_NOP;
    endcase
  end

  slmpd_fifo #(
    .Width($bits(slmpd_pkg::cmd_t)),
    .Depth(slmpd_pkg::FIFO_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (dec),
    .full_o (full),
    .pop_i  (cmd_ready_i),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = slmpd_pkg::cmd_t'(q_data);

endmodule

`default_nettype wire

>>> sv/slmpd_back.sv
// back end: ring, frame store, pwm scan and the result queue
// depends on slmpd_pkg, slmpd_fifo and the assertion macro header
`default_nettype none
`include "spi_led_matrix_pwm_driver_core_defines.svh"

module slmpd_back #(
  parameter int unsigned PwmSlots = slmpd_pkg::PWM_SLOTS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  input  wire slmpd_pkg::cmd_t  cmd_i,
  output logic                  empty,
  input  wire logic             pop,
  output slmpd_pkg::out_word_t  word_o
);

  localparam int unsigned SlotW = $clog2(PwmSlots);
  localparam int unsigned CmpW  = (SlotW > slmpd_pkg::LEVEL_W) ? SlotW : slmpd_pkg::LEVEL_W;
  localparam int unsigned IdxW  = slmpd_pkg::IDX_W;
  localparam int unsigned ColW  = slmpd_pkg::COL_W;
  localparam int unsigned WordW = 4 * slmpd_pkg::ROWS;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(PwmSlots - 1);

  logic [7:0]       ring_q  [slmpd_pkg::RING_BYTES];
  logic [WordW-1:0] frame_q [slmpd_pkg::COLUMNS];
  logic [IdxW-1:0]  wi_q, wi_d;
  logic             seen_q, seen_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             exec, ring_we, latch_en, res_full;
  logic [WordW-1:0] col_word;
  slmpd_pkg::out_word_t res;
  logic [$bits(slmpd_pkg::out_word_t)-1:0] q_data;

  assign exec        = cmd_valid_i && !res_full;
  assign cmd_ready_o = !res_full;
  assign col_word    = frame_q[col_q];

  always_comb begin
    wi_d          = wi_q;
    seen_d        = seen_q;
    slot_d        = slot_q;
    col_d         = col_q;
    ring_we       = 1'b0;
    latch_en      = 1'b0;
    res.col_drive = '0;
    res.row_drive = '0;
    unique case (cmd_i.op)
      slmpd_pkg::OP_BYTE: begin
        ring_we = 1'b1;
        wi_d    = wi_q + 1'b1;
        seen_d  = 1'b1;
      end
      slmpd_pkg::OP_LATCH: begin
        if (seen_q) begin
          latch_en = 1'b1;
          wi_d     = '0;
          seen_d   = 1'b0;
        end
      end
      slmpd_pkg::OP_TICK: begin
        res.col_drive = 8'(1) << col_q;
        for (int r = 0; r < slmpd_pkg::ROWS; r++) begin
          res.row_drive[r] = CmpW'(slot_q) < CmpW'(slmpd_pkg::pwm_level(col_word[4*r +: 4]));
        end
        if (slot_q == SlotLast) begin
          slot_d = '0;
          col_d  = col_q + 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      default: ;
    endcase
    // the written slot never equals the next read slot
    res.tx_byte = ring_q[wi_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      seen_q <= 1'b0;
      slot_q <= '0;
      col_q  <= '0;
      for (int i = 0; i < slmpd_pkg::RING_BYTES; i++) begin
        ring_q[i] <= '0;
      end
      for (int c = 0; c < slmpd_pkg::COLUMNS; c++) begin
        frame_q[c] <= '0;
      end
    end else if (exec) begin
      wi_q   <= wi_d;
      seen_q <= seen_d;
      slot_q <= slot_d;
      col_q  <= col_d;
      if (ring_we) begin
        ring_q[wi_q] <= cmd_i.data;
      end
      if (latch_en) begin
        for (int c = 0; c < slmpd_pkg::COLUMNS; c++) begin
          for (int k = 0; k < slmpd_pkg::ROWS / 2; k++) begin
            frame_q[c][8*k +: 8] <= ring_q[4*c + k];
          end
        end
      end
    end
  end

  slmpd_fifo #(
    .Width($bits(slmpd_pkg::out_word_t)),
    .Depth(slmpd_pkg::FIFO_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (exec),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (q_data),
    .empty_o(empty)
  );

  assign word_o = slmpd_pkg::out_word_t'(q_data);

  `SLMPD_ASSERT_IMP(a_tick_onehot, clk_i, rst_ni, exec && cmd_i.op == slmpd_pkg::OP_TICK,
                    $onehot(res.col_drive), "tick result has no one-hot column")
  `SLMPD_ASSERT_IMP(a_quiet_drives, clk_i, rst_ni, exec && cmd_i.op != slmpd_pkg::OP_TICK,
                    res.col_drive == '0 && res.row_drive == '0, "drives set outside a tick")
  `SLMPD_ASSERT_NEXT(a_latch_clears, clk_i, rst_ni,
                     exec && cmd_i.op == slmpd_pkg::OP_LATCH && seen_q,
                     wi_q == '0 && !seen_q, "latch left index or flag set")
  `SLMPD_ASSERT_ALWAYS(a_slot_range, clk_i, rst_ni, slot_q <= SlotLast,
                       "pwm slot out of range")

endmodule

`default_nettype wire

>>> sv/spi_led_matrix_pwm_driver_core.sv
// top level of the 8x8 led matrix driver with spi ring and pwm column scan
// depends on slmpd_pkg, slmpd_front and slmpd_back
`default_nettype none

// Takes one word per clock while full is low: a received spi byte, a
// chip-select release that latches the 32-byte ring into the frame store if
// a byte came in since the last latch, a scan tick or a no-op, and gives one
// result word for each: the next transmit byte, and on a tick the one-hot
// column and the row enables of the current pwm slot. A word is written into
// the decode queue; the execute step is combinational and writes its result
// into the result queue, from which the result word can then be popped. Both
// queues are two words deep, so pushes and pops run at one word per cycle
// while the result side keeps taking words. The rate is set by the
// combinational execute step that updates ring, frame and scan position. Ring
// and frame store are cleared by reset; there is no clearing pass.
module spi_led_matrix_pwm_driver_core #(
  parameter int unsigned PwmSlots = slmpd_pkg::PWM_SLOTS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire slmpd_pkg::in_word_t  in_word_i,
  output logic                      empty,
  input  wire logic                 pop,
  output slmpd_pkg::out_word_t      out_word_o
);

  logic            cmd_valid, cmd_ready;
  slmpd_pkg::cmd_t cmd;

  slmpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .word_i     (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  slmpd_back #(
    .PwmSlots(PwmSlots)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .empty      (empty),
    .pop        (pop),
    .word_o     (out_word_o)
  );

endmodule

`default_nettype wire

>>> tb/spi_led_matrix_pwm_driver_core_tb.sv
// self-checking testbench for spi_led_matrix_pwm_driver_core: ring, latch and pwm scan
// a queue-fed driver and a monitor with a built-in predictor of the matrix driver
// depends on slmpd_pkg and spi_led_matrix_pwm_driver_core
`default_nettype none

module spi_led_matrix_pwm_driver_core_tb;

  localparam int unsigned CYCLE_LIMIT = 40000;
  localparam int unsigned RAND_WORDS  = 450;
  localparam int unsigned IDLE_PCT    = 38;

  typedef struct {
    slmpd_pkg::in_word_t word;
    bit                  drain;
  } feed_t;

  logic                 clk     = 1'b0;
  logic                 rst_n   = 1'b0;
  logic                 push    = 1'b0;
  logic                 pop     = 1'b0;
  slmpd_pkg::in_word_t  in_word = '0;
  logic                 full;
  logic                 empty;
  slmpd_pkg::out_word_t out_word;

  feed_t                feed_q[$];
  slmpd_pkg::out_word_t drive_q[$];
  int        n_sent    = 0;
  int        n_taken   = 0;
  int        total     = 0;
  int        errors    = 0;
  int        cycle_cnt = 0;
  logic      quiet;

  // predictor state
  bit [7:0] ring_m [32];
  bit [7:0] frame_m [32];
  bit [4:0] wr_idx_m;
  bit       seen_m;
  bit [5:0] slot_m;
  bit [2:0] col_m;
  bit [5:0] level_tab [16];

  spi_led_matrix_pwm_driver_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign quiet = (n_taken >= 200) && (n_taken < 330);

  function automatic slmpd_pkg::out_word_t step_matrix(input slmpd_pkg::in_word_t w);
    slmpd_pkg::out_word_t r;
    bit [7:0]  b;
    bit [3:0]  nib;
    r = '0;
    case (w.func)
      slmpd_pkg::FUNC_BYTE: begin
        ring_m[wr_idx_m] = w.rx_byte;
        wr_idx_m = wr_idx_m + 5'd1;
        seen_m = 1'b1;
      end
      slmpd_pkg::FUNC_LATCH: begin
        if (seen_m) begin
          frame_m = ring_m;
          wr_idx_m = '0;
          seen_m = 1'b0;
        end
      end
      slmpd_pkg::FUNC_TICK: begin
        r.col_drive = 8'h01 << col_m;
        for (int k = 0; k < slmpd_pkg::ROWS; k++) begin
          b = frame_m[col_m * 4 + k / 2];
          nib = k[0] ? b[7:4] : b[3:0];
          if (slot_m < level_tab[nib]) r.row_drive[k] = 1'b1;
        end
        if (slot_m + 1 >= slmpd_pkg::PWM_SLOTS) begin
          slot_m = '0;
          col_m = col_m + 3'd1;
        end else begin
          slot_m = slot_m + 6'd1;
        end
      end
      default: begin
      end
    endcase
    r.tx_byte = ring_m[wr_idx_m];
    return r;
  endfunction

  task automatic add_word(input logic [1:0] func, input logic [7:0] data, input bit drain);
    feed_t f;
    f.word.func    = func;
    f.word.rx_byte = data;
    f.drain        = drain;
    feed_q.push_back(f);
  endtask

  task automatic cmp_byte(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s expected %02h actual %02h", $time, what, want, got);
      errors++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || n_taken == n_sent) begin
      if (feed_q.size() == 0) begin
        push <= 1'b0;
      end else if (feed_q[0].drain && drive_q.size() != 0) begin
        push <= 1'b0;
      end else if (!quiet && $urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
      end else begin
        in_word <= feed_q[0].word;
        push    <= 1'b1;
        void'(feed_q.pop_front());
        n_sent++;
      end
    end
  end

  always @(negedge clk) begin
    pop <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  // monitor
  always @(posedge clk) begin : mon
    slmpd_pkg::out_word_t want;
    cycle_cnt++;
    if (rst_n) begin
      if (push && !full) begin
        drive_q.push_back(step_matrix(in_word));
        n_taken++;
      end
      if (pop && !empty) begin
        if (drive_q.size() == 0) begin
          $display("%0t unexpected word expected none actual %06h", $time, out_word);
          errors++;
        end else begin
          want = drive_q.pop_front();
          cmp_byte("tx_byte", want.tx_byte, out_word.tx_byte);
          cmp_byte("col_drive", want.col_drive, out_word.col_drive);
          cmp_byte("row_drive", want.row_drive, out_word.row_drive);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int kind;
    int n;
    int grp;
    level_tab = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
                  6'd8, 6'd11, 6'd15, 6'd20, 6'd26, 6'd35, 6'd47, 6'd63};

    // directed part
    add_word(slmpd_pkg::FUNC_TICK, 8'h00, 1'b0);
    add_word(slmpd_pkg::FUNC_LATCH, 8'h00, 1'b0);
    add_word(slmpd_pkg::FUNC_NOP, 8'hff, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'hff, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'h00, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'hf0, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'h0f, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'h5a, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'ha5, 1'b0);
    add_word(slmpd_pkg::FUNC_NOP, 8'h00, 1'b0);
    add_word(slmpd_pkg::FUNC_LATCH, 8'h00, 1'b0);
    repeat (4) add_word(slmpd_pkg::FUNC_TICK, 8'h00, 1'b0);
    add_word(slmpd_pkg::FUNC_BYTE, 8'h3c, 1'b0);
    add_word(slmpd_pkg::FUNC_LATCH, 8'hff, 1'b0);
    add_word(slmpd_pkg::FUNC_TICK, 8'hff, 1'b0);
    add_word(slmpd_pkg::FUNC_LATCH, 8'hff, 1'b0);
    add_word(slmpd_pkg::FUNC_TICK, 8'hff, 1'b0);

    // random part: mostly frames and tick bursts, some noise
    grp = 0;
    n = feed_q.size() + RAND_WORDS;
    while (feed_q.size() < n) begin
      kind = $urandom_range(99);
      grp++;
      if (kind < 45) begin
        repeat ($urandom_range(60, 10))
          add_word(slmpd_pkg::FUNC_TICK, 8'($urandom), 1'b0);
      end else if (kind < 70) begin
        repeat (32) add_word(slmpd_pkg::FUNC_BYTE, 8'($urandom), 1'b0);
        add_word(slmpd_pkg::FUNC_LATCH, 8'($urandom), 1'b0);
      end else if (kind < 82) begin
        repeat ($urandom_range(45, 1))
          add_word(slmpd_pkg::FUNC_BYTE, 8'($urandom), 1'b0);
        if ($urandom_range(1)) add_word(slmpd_pkg::FUNC_LATCH, 8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(4, 1))
          add_word(2'($urandom_range(3)), 8'($urandom), 1'b0);
      end
      if (grp == 4 || grp == 15) feed_q[feed_q.size() - 1].drain = 1'b1;
    end
    total = feed_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken != total) @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
